// ===== rtl/bsmdu_pkg.sv =====
// Package for the bit-serial multiply/divide unit.
// Holds the field widths, the operation codes and the result record type.
// No dependencies.
`default_nettype none

package bsmdu_pkg;

  localparam int CountW = 5;
  localparam int RegW   = 16;
  localparam int ShiftW = 24;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic [RegW-1:0] product_remainder;
    logic [RegW-1:0] quotient_multiplier;
    logic            busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bit_serial_multiply_divide_unit_core.sv =====
// Bit-serial multiply/divide unit: up to one shift-add and one restoring-divide
// step per tick request while its count is nonzero, or a direct load of all state.
// Depends on bsmdu_pkg.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------
//   in      | to unit   | in_valid/in_stall | op, load_mult_steps, load_div_steps,
//           |           |                   | load_quotient, load_product, load_shift
//   out     | from unit | out_valid/out_stall| product_remainder,
//           |           |                   | quotient_multiplier, busy_res
//
// One request per clock cycle while in_stall is low; results are registered.
// The state registers update in the same cycle a request is taken; the
// multiply add feeding the divide compare-subtract sets the cycle path.
// A two-entry output buffer (result register plus skid) keeps the input open
// for one more request while a result is stalled.
// Synchronous active-high rst clears the step counts, working registers and
// the output valid flags.
`default_nettype none

module bit_serial_multiply_divide_unit_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              op,
  input  wire  [bsmdu_pkg::CountW-1:0]     load_mult_steps,
  input  wire  [bsmdu_pkg::CountW-1:0]     load_div_steps,
  input  wire  [bsmdu_pkg::RegW-1:0]       load_quotient,
  input  wire  [bsmdu_pkg::RegW-1:0]       load_product,
  input  wire  [bsmdu_pkg::ShiftW-1:0]     load_shift,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [bsmdu_pkg::RegW-1:0]       product_remainder,
  output logic [bsmdu_pkg::RegW-1:0]       quotient_multiplier,
  output logic                             busy_res
);

  localparam int CW = bsmdu_pkg::CountW;
  localparam int RW = bsmdu_pkg::RegW;
  localparam int SW = bsmdu_pkg::ShiftW;

  logic [CW-1:0] mult_count, mult_count_next;
  logic [CW-1:0] div_count, div_count_next;
  logic [RW-1:0] quot_reg, quot_reg_next;
  logic [RW-1:0] prod_reg, prod_reg_next;
  logic [SW-1:0] shift_reg, shift_reg_next;

  bsmdu_pkg::result_t main_res, skid_res, new_res;
  logic               skid_valid;
  logic               accept_in;
  logic               main_free;

  // Intermediate values after the multiply step.
  logic [RW-1:0] m_quot, m_prod;
  logic [SW-1:0] m_shift;
  logic [CW-1:0] m_count;
  // Divide step.
  logic [SW-1:0] d_shift;
  logic          d_fits;
  logic [RW-1:0] d_prod, d_quot;
  logic [CW-1:0] d_count;

  assign in_stall  = skid_valid;
  assign accept_in = in_valid && !in_stall;
  assign main_free = !out_valid || !out_stall;

  always_comb begin
    // multiply step, skipped when no multiply is pending
    m_count = mult_count;
    m_quot  = quot_reg;
    m_prod  = prod_reg;
    m_shift = shift_reg;
    if (mult_count != '0) begin
      m_count = mult_count - CW'(1);
      if (quot_reg[0]) begin
        m_prod = prod_reg + shift_reg[RW-1:0];
      end
      m_quot  = quot_reg >> 1;
      m_shift = shift_reg << 1;
    end

    // divide step on the multiply result
    d_count = m_count;
    d_quot  = m_quot;
    d_prod  = m_prod;
    d_shift = m_shift;
    d_fits  = 1'b0;
    if (div_count != '0) begin
      d_count = div_count - CW'(1);
      d_shift = m_shift >> 1;
      d_fits  = {{(SW-RW){1'b0}}, m_prod} >= d_shift;
      d_prod  = d_fits ? (m_prod - d_shift[RW-1:0]) : m_prod;
      d_quot  = {m_quot[RW-2:0], d_fits};
    end

    if (op == bsmdu_pkg::OP_LOAD) begin
      mult_count_next = load_mult_steps;
      div_count_next  = load_div_steps;
      quot_reg_next   = load_quotient;
      prod_reg_next   = load_product;
      shift_reg_next  = load_shift;
    end else begin
      mult_count_next = d_count;
      div_count_next  = d_count == m_count ? div_count : d_count;
      quot_reg_next   = d_quot;
      prod_reg_next   = d_prod;
      shift_reg_next  = d_shift;
      if (div_count != '0) begin
        mult_count_next = m_count;
        div_count_next  = d_count;
      end
    end

    new_res.product_remainder   = prod_reg_next;
    new_res.quotient_multiplier = quot_reg_next;
    new_res.busy_res            = (mult_count_next != '0) || (div_count_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_count <= '0;
      div_count  <= '0;
      quot_reg   <= '0;
      prod_reg   <= '0;
      shift_reg  <= '0;
    end else if (accept_in) begin
      mult_count <= mult_count_next;
      div_count  <= div_count_next;
      quot_reg   <= quot_reg_next;
      prod_reg   <= prod_reg_next;
      shift_reg  <= shift_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      // drain the skid first; the input is stalled while it is full
      if (skid_valid) begin
        main_res   <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        if (accept_in) begin
          main_res <= new_res;
        end
        out_valid <= accept_in;
      end
    end else if (accept_in) begin
      skid_res   <= new_res;
      skid_valid <= 1'b1;
    end
  end

  assign product_remainder   = main_res.product_remainder;
  assign quotient_multiplier = main_res.quotient_multiplier;
  assign busy_res            = main_res.busy_res;

endmodule

`default_nettype wire

// ===== rtl/bsmdu_checker.sv =====
// Port-level checks for the bit-serial multiply/divide unit.
// Depends on bsmdu_pkg; bound to bit_serial_multiply_divide_unit_core.
`default_nettype none

module bsmdu_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire                          op,
  input wire [bsmdu_pkg::CountW-1:0]  load_mult_steps,
  input wire [bsmdu_pkg::CountW-1:0]  load_div_steps,
  input wire [bsmdu_pkg::RegW-1:0]    load_quotient,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [bsmdu_pkg::RegW-1:0]    product_remainder,
  input wire [bsmdu_pkg::RegW-1:0]    quotient_multiplier,
  input wire                          busy_res
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product_remainder)
      && $stable(quotient_multiplier) && $stable(busy_res))
    else $error("stalled result changed");

  // the input only stalls behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // a request into an empty buffer shows next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("accepted request produced no result");

  // a load with zero step counts is idle and returns the loaded quotient
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && op == bsmdu_pkg::OP_LOAD
      && load_mult_steps == '0 && load_div_steps == '0
    |=> !busy_res && quotient_multiplier == $past(load_quotient))
    else $error("idle load returned wrong result");

endmodule

bind bit_serial_multiply_divide_unit_core bsmdu_checker u_bsmdu_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .op                  (op),
  .load_mult_steps     (load_mult_steps),
  .load_div_steps      (load_div_steps),
  .load_quotient       (load_quotient),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .product_remainder   (product_remainder),
  .quotient_multiplier (quotient_multiplier),
  .busy_res            (busy_res)
);

`default_nettype wire
